// File: sv/apc_pkg.sv
// Package for the alpha preview pixel converter.
// Holds the register indexes, mode codes, pixel type and the alpha scaling function.
// No dependencies.
`default_nettype none

package apc_pkg;

	localparam int FRAME_WIDTH_W = 13;
	localparam int CFG_DATA_W    = 13;
	localparam int CFG_INDEX_W   = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_PREVIEW_MODE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd1;

	localparam logic [1:0] MODE_NONE        = 2'd0;
	localparam logic [1:0] MODE_CUTOUT      = 2'd1;
	localparam logic [1:0] MODE_TRANSPARENT = 2'd2;

	localparam logic [7:0] GRAY_ODD = 8'h55;
	localparam logic [7:0] OPAQUE   = 8'hFF;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgba_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	// floor(c*a/255) + gray, saturated at 255.
	// The divide by 255 is (p + (p >> 8) + 1) >> 8, exact for any product of two 8-bit values.
	function automatic logic [7:0] scale_add(input logic [7:0] c, input logic [7:0] a,
			input logic [7:0] gray);
		logic [15:0] prod;
		logic [16:0] acc;
		logic [7:0]  quot;
		logic [8:0]  sum;
		prod = c * a;
		acc  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
		quot = acc[15:8];
		sum  = {1'b0, quot} + {1'b0, gray};
		scale_add = sum[8] ? 8'hFF : sum[7:0];
	endfunction

endpackage

`default_nettype wire

// File: sv/alpha_preview_pixel_convert_unit.sv
// Alpha preview pixel converter, top level.
// Uses apc_pkg for register indexes, mode codes, pixel types and scaling.
//
// Usage:
//   s_axis carries one RGBA pixel per item in raster order; tuser flags the first
//   pixel of a frame, which puts the checkerboard position back to the origin.
//   m_axis gives one opaque RGB pixel per input item, in order.
//   cfg writes the preview mode (index 0) or frame_width (index 1); cfg_ready is
//   always high. Write only while no pixel is in flight.
// Path: an accepted item passes the input register, then the result register,
//   which drives m_axis. Throughput: one item per cycle while m_axis_tready is
//   high; the scale-and-add logic between the two registers is combinational,
//   with one 8x8 multiply per channel.
// Stall: while m_axis_tready is low the result register holds and the input
//   register fills; s_axis_tready drops only when both are occupied.
// Reset: arst_n clears the pipeline valids, the position counters, the preview
//   mode to none and frame_width to 1.
`default_nettype none

module alpha_preview_pixel_convert_unit
	import apc_pkg::*;
#(
	parameter int MAX_WIDTH    = 4096,
	parameter int CHECKER_CELL = 5
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	input  wire logic                   s_axis_tvalid,
	output      logic                   s_axis_tready,
	input  wire logic [31:0]            s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
	input  wire logic                   s_axis_tuser,   // start_frame

	output      logic                   m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output      logic [23:0]            m_axis_tdata,   // out_red, out_green, out_blue

	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW_RAW = $clog2(MAX_WIDTH);
	localparam int CW     = (CW_RAW < 1) ? 1 : CW_RAW;
	localparam int EW     = (CW + 1 > FRAME_WIDTH_W) ? CW + 1 : FRAME_WIDTH_W;
	localparam int PW_RAW = $clog2(CHECKER_CELL);
	localparam int PW     = (PW_RAW < 1) ? 1 : PW_RAW;

	localparam logic [EW-1:0]   MAX_W_E = EW'(MAX_WIDTH);
	localparam logic [PW:0]     CELL_E  = (PW + 1)'(CHECKER_CELL);

	// configuration
	logic [1:0]               preview_mode_q;
	logic [FRAME_WIDTH_W-1:0] frame_width_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preview_mode_q <= MODE_NONE;
			frame_width_q  <= FRAME_WIDTH_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PREVIEW_MODE: preview_mode_q <= cfg_data[1:0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FRAME_WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic  valid_s1;
	logic  out_valid_q;
	logic  out_adv;
	logic  in_acc;

	assign out_adv       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || out_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// position tracking
	logic [CW-1:0] col_q;
	logic [PW-1:0] col_phase_q;
	logic          col_par_q;
	logic [PW-1:0] row_phase_q;
	logic          row_par_q;

	logic [CW-1:0] col_cur;
	logic [PW-1:0] col_phase_cur;
	logic          col_par_cur;
	logic [PW-1:0] row_phase_cur;
	logic          row_par_cur;
	logic [EW-1:0] eff_width;
	logic [EW-1:0] col_next_e;
	logic          row_end;
	logic [PW:0]   col_phase_inc;
	logic [PW:0]   row_phase_inc;

	always_comb begin
		if (s_axis_tuser) begin
			col_cur       = '0;
			col_phase_cur = '0;
			col_par_cur   = 1'b0;
			row_phase_cur = '0;
			row_par_cur   = 1'b0;
		end else begin
			col_cur       = col_q;
			col_phase_cur = col_phase_q;
			col_par_cur   = col_par_q;
			row_phase_cur = row_phase_q;
			row_par_cur   = row_par_q;
		end

		eff_width = EW'(frame_width_q);
		if (eff_width == '0)
			eff_width = EW'(1);
		if (eff_width > MAX_W_E)
			eff_width = MAX_W_E;

		col_next_e    = EW'(col_cur) + EW'(1);
		row_end       = col_next_e >= eff_width;
		col_phase_inc = {1'b0, col_phase_cur} + (PW + 1)'(1);
		row_phase_inc = {1'b0, row_phase_cur} + (PW + 1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			col_phase_q <= '0;
			col_par_q   <= 1'b0;
			row_phase_q <= '0;
			row_par_q   <= 1'b0;
		end else if (in_acc) begin
			if (row_end) begin
				col_q       <= '0;
				col_phase_q <= '0;
				col_par_q   <= 1'b0;
				if (row_phase_inc >= CELL_E) begin
					row_phase_q <= '0;
					row_par_q   <= !row_par_cur;
				end else begin
					row_phase_q <= row_phase_inc[PW-1:0];
					row_par_q   <= row_par_cur;
				end
			end else begin
				col_q       <= col_next_e[CW-1:0];
				row_phase_q <= row_phase_cur;
				row_par_q   <= row_par_cur;
				if (col_phase_inc >= CELL_E) begin
					col_phase_q <= '0;
					col_par_q   <= !col_par_cur;
				end else begin
					col_phase_q <= col_phase_inc[PW-1:0];
					col_par_q   <= col_par_cur;
				end
			end
		end
	end

	// input register
	rgba_t      pix_s1;
	logic [7:0] gray_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= rgba_t'(s_axis_tdata);
			gray_s1 <= (col_par_cur ^ row_par_cur) ? GRAY_ODD : 8'h00;
		end
	end

	// color conversion
	rgb_t res;

	always_comb begin
		res.red   = pix_s1.red;
		res.green = pix_s1.green;
		res.blue  = pix_s1.blue;
		if (pix_s1.alpha != OPAQUE) begin
			case (preview_mode_q)
				MODE_CUTOUT: begin
					res.red   = 8'h00;
					res.green = 8'h00;
					res.blue  = OPAQUE;
				end
				MODE_TRANSPARENT: begin
					res.red   = scale_add(pix_s1.red, pix_s1.alpha, gray_s1);
					res.green = scale_add(pix_s1.green, pix_s1.alpha, gray_s1);
					res.blue  = scale_add(pix_s1.blue, pix_s1.alpha, gray_s1);
				end
				default: ;
			endcase
		end
	end

	// result register
	rgb_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1)
			out_data_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// checks
	a_col_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_phase_q} < CELL_E)
		else $error("column cell phase out of range");

	a_row_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, row_phase_q} < CELL_E)
		else $error("row cell phase out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		EW'(col_q) < MAX_W_E)
		else $error("column count beyond maximum width");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_adv |=> valid_s1 && $stable(pix_s1))
		else $error("stalled item lost from input register");

endmodule

`default_nettype wire

// File: tb/sv/tb_alpha_preview_pixel_convert_unit.sv
// Self-checking testbench for alpha_preview_pixel_convert_unit.
// A directed table followed by random frames, checked against expected values in the
// table or a checkerboard preview model kept in this file. Depends on apc_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_alpha_preview_pixel_convert_unit
	import apc_pkg::*;
();

	localparam int             FRAME_WIDTH_MAX = 4096;
	localparam int             CELL            = 5;
	localparam logic [1:0]     MODE_UNUSED     = 2'd3;
	localparam int             STALL_LIMIT     = 5000;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [31:0]            s_axis_tdata  = '0;   // in_red, in_green, in_blue, in_alpha
	logic                   s_axis_tuser  = 1'b0; // start_frame
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b1;
	logic [23:0]            m_axis_tdata;         // out_red, out_green, out_blue
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;

	alpha_preview_pixel_convert_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	typedef struct {
		bit                     is_cfg;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0]  data;
		bit                     start;
		rgba_t                  px;
		bit                     typed;
		rgb_t                   want;
	} step_t;

	// model copy of registers and checkerboard position
	logic [1:0]            cur_mode  = MODE_NONE;
	logic [CFG_DATA_W-1:0] cur_width = CFG_DATA_W'(1);
	int                    board_col;
	int                    board_col_phase;
	bit                    board_col_odd;
	int                    board_row_phase;
	bit                    board_row_odd;

	rgb_t  expected_pixels[$];
	step_t steps[$];
	int    mismatch_count = 0;
	int    random_sent    = 0;
	int    ready_hold     = 0;
	int    quiet_cycles   = 0;
	bit    calm           = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] fade_channel(logic [7:0] c, logic [7:0] a, logic [7:0] gray);
		int v;
		v = (int'(c) * int'(a)) / 255 + int'(gray);
		return (v > 255) ? 8'hFF : 8'(v);
	endfunction

	task automatic preview_pixel(input bit start, input rgba_t px, output rgb_t res);
		logic [7:0] gray;
		int         span;
		if (start) begin
			board_col       = 0;
			board_col_phase = 0;
			board_col_odd   = 1'b0;
			board_row_phase = 0;
			board_row_odd   = 1'b0;
		end
		gray = (board_col_odd ^ board_row_odd) ? GRAY_ODD : 8'h00;
		res.red   = px.red;
		res.green = px.green;
		res.blue  = px.blue;
		if (px.alpha != OPAQUE) begin
			if (cur_mode == MODE_CUTOUT) begin
				res.red   = 8'h00;
				res.green = 8'h00;
				res.blue  = OPAQUE;
			end else if (cur_mode == MODE_TRANSPARENT) begin
				res.red   = fade_channel(px.red, px.alpha, gray);
				res.green = fade_channel(px.green, px.alpha, gray);
				res.blue  = fade_channel(px.blue, px.alpha, gray);
			end
		end
		span = (cur_width == 0) ? 1 : int'(cur_width);
		if (span > FRAME_WIDTH_MAX)
			span = FRAME_WIDTH_MAX;
		if (board_col + 1 >= span) begin
			board_col       = 0;
			board_col_phase = 0;
			board_col_odd   = 1'b0;
			board_row_phase++;
			if (board_row_phase >= CELL) begin
				board_row_phase = 0;
				board_row_odd   = ~board_row_odd;
			end
		end else begin
			board_col++;
			board_col_phase++;
			if (board_col_phase >= CELL) begin
				board_col_phase = 0;
				board_col_odd   = ~board_col_odd;
			end
		end
	endtask

	function automatic step_t cfg_step(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		step_t s;
		s        = '{default: '0};
		s.is_cfg = 1'b1;
		s.idx    = idx;
		s.data   = data;
		return s;
	endfunction

	function automatic step_t pixel_step(bit start, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] a);
		step_t s;
		s       = '{default: '0};
		s.start = start;
		s.px    = '{alpha: a, blue: b, green: g, red: r};
		return s;
	endfunction

	function automatic step_t checked_step(bit start, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] a, logic [7:0] wr, logic [7:0] wg, logic [7:0] wb);
		step_t s;
		s       = pixel_step(start, r, g, b, a);
		s.typed = 1'b1;
		s.want  = '{blue: wb, green: wg, red: wr};
		return s;
	endfunction

	function automatic logic [7:0] rand_channel();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return 8'h00;
		if (pick == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic rgba_t rand_pixel();
		rgba_t px;
		int    pick;
		pick = $urandom_range(0, 7);
		case (pick)
			0, 1, 2: px.alpha = OPAQUE;
			3:       px.alpha = 8'h00;
			4:       px.alpha = 8'hFE;
			default: px.alpha = 8'($urandom_range(0, 255));
		endcase
		px.red   = rand_channel();
		px.green = rand_channel();
		px.blue  = rand_channel();
		return px;
	endfunction

	// registers change only with the pipe empty; valid stays up when another write follows
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
			input bit drop);
		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_PREVIEW_MODE)
			cur_mode = data[1:0];
		else
			cur_width = data;
		if (drop)
			cfg_valid <= 1'b0;
	endtask

	task automatic push_pixel(input bit start, input rgba_t px, input bit typed, input rgb_t want);
		rgb_t res;
		int   gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 10);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		s_axis_tuser  <= start;
		do @(posedge clk); while (!s_axis_tready);
		preview_pixel(start, px, res);
		expected_pixels.push_back(typed ? want : res);
	endtask

	task automatic run_phase();
		logic [CFG_DATA_W-1:0] w;
		int                    n;
		case ($urandom_range(0, 19))
			0:       w = '0;
			1:       w = CFG_DATA_W'(FRAME_WIDTH_MAX);
			2:       w = CFG_DATA_W'($urandom_range(FRAME_WIDTH_MAX + 1, 8191));
			3:       w = CFG_DATA_W'($urandom_range(1, 8191));
			default: w = CFG_DATA_W'($urandom_range(1, 12));
		endcase
		write_reg(REG_PREVIEW_MODE, CFG_DATA_W'($urandom_range(0, 3)), 1'b0);
		write_reg(REG_FRAME_WIDTH, w, 1'b1);
		n = $urandom_range(8, 60);
		for (int k = 0; k < n; k++)
			push_pixel((k == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 31) == 0,
				rand_pixel(), 1'b0, '0);
		random_sent += n;
	endtask

	// result side: random stall bursts, always ready in the calm tail
	always @(posedge clk) begin
		if (calm) begin
			m_axis_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
		end else if ($urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			ready_hold = $urandom_range(0, 9);
		end else begin
			m_axis_tready <= 1'b1;
			ready_hold = $urandom_range(1, 20);
		end
	end

	always @(posedge clk) begin
		rgb_t got;
		rgb_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = rgb_t'(m_axis_tdata);
			if (expected_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result item r=%h g=%h b=%h", got.red, got.green, got.blue);
			end else begin
				want = expected_pixels.pop_front();
				if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
							want.red, want.green, want.blue, got.red, got.green, got.blue);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_alpha_preview_pixel_convert_unit failed");
				$finish;
			end
		end
	end

	initial begin
		board_col       = 0;
		board_col_phase = 0;
		board_col_odd   = 1'b0;
		board_row_phase = 0;
		board_row_odd   = 1'b0;

		// registers at reset values
		steps.push_back(checked_step(1'b1, 8'h12, 8'h34, 8'h56, 8'h00, 8'h12, 8'h34, 8'h56));
		steps.push_back(checked_step(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF));
		// cut-out
		steps.push_back(cfg_step(REG_PREVIEW_MODE, CFG_DATA_W'(MODE_CUTOUT)));
		steps.push_back(checked_step(1'b1, 8'h10, 8'h20, 8'h30, 8'h00, 8'h00, 8'h00, 8'hFF));
		steps.push_back(checked_step(1'b0, 8'h10, 8'h20, 8'h30, 8'hFF, 8'h10, 8'h20, 8'h30));
		steps.push_back(checked_step(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'h00, 8'h00, 8'hFF));
		// unused mode code acts as passthrough
		steps.push_back(cfg_step(REG_PREVIEW_MODE, CFG_DATA_W'(MODE_UNUSED)));
		steps.push_back(checked_step(1'b0, 8'h01, 8'h02, 8'h03, 8'h07, 8'h01, 8'h02, 8'h03));
		// transparent, width 0 behaves as one pixel per row: row cell flips every 5 items
		steps.push_back(cfg_step(REG_PREVIEW_MODE, CFG_DATA_W'(MODE_TRANSPARENT)));
		steps.push_back(cfg_step(REG_FRAME_WIDTH, '0));
		steps.push_back(checked_step(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		steps.push_back(checked_step(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
		steps.push_back(pixel_step(1'b0, 8'hFF, 8'h80, 8'h01, 8'h80));
		steps.push_back(pixel_step(1'b0, 8'h40, 8'hC0, 8'hFF, 8'h7F));
		steps.push_back(pixel_step(1'b0, 8'h9A, 8'h00, 8'h65, 8'h01));
		steps.push_back(checked_step(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h55, 8'h55, 8'h55));
		steps.push_back(checked_step(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFF, 8'hFF, 8'hFF));
		steps.push_back(pixel_step(1'b0, 8'hAA, 8'h55, 8'h3C, 8'hC3));
		// oversized width, then shrink to 1 in the middle of the row
		steps.push_back(cfg_step(REG_FRAME_WIDTH, '1));
		steps.push_back(pixel_step(1'b1, 8'h80, 8'h80, 8'h80, 8'h80));
		steps.push_back(pixel_step(1'b0, 8'h7F, 8'hEE, 8'h11, 8'hF0));
		steps.push_back(cfg_step(REG_FRAME_WIDTH, CFG_DATA_W'(1)));
		steps.push_back(pixel_step(1'b0, 8'hC8, 8'h64, 8'h32, 8'h99));
		steps.push_back(pixel_step(1'b0, 8'h21, 8'h43, 8'h65, 8'h87));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < steps.size(); i++) begin
			if (steps[i].is_cfg)
				write_reg(steps[i].idx, steps[i].data,
					!(i + 1 < steps.size() && steps[i + 1].is_cfg));
			else
				push_pixel(steps[i].start, steps[i].px, steps[i].typed, steps[i].want);
		end

		while (random_sent < 780)
			run_phase();

		calm = 1'b1;
		while (random_sent < 930)
			run_phase();
		s_axis_tvalid <= 1'b0;

		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatch_count == 0 && expected_pixels.size() == 0)
			$display("tb_alpha_preview_pixel_convert_unit passed");
		else
			$display("tb_alpha_preview_pixel_convert_unit failed");
		$finish;
	end

endmodule
